### rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache policy block.
// No dependencies; imported by lfu_scan and lfu_cache_policy.
`default_nettype none

package lfu_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	// action codes
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	localparam logic [DATA_W-1:0] WORD_MAX       = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] GET_MISS_VALUE = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] FIRST_COUNT    = {{(DATA_W-1){1'b0}}, 1'b1};
	localparam logic [CAP_W-1:0]  CAP_RESET      = CAP_W'(16);

	// one slot as held in the slot memory
	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] use_count;
		logic [DATA_W-1:0] order_stamp;
	} lfu_entry_t;

	// outcome of one pass over the occupied slots
	typedef struct packed {
		logic       match_found;
		lfu_entry_t match_entry;
		lfu_entry_t victim_entry;
	} lfu_scan_t;

	// saturating increment of a count or stamp
	function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
		sat_inc = (v != WORD_MAX) ? v + FIRST_COUNT : v;
	endfunction

endpackage

`default_nettype wire

### rtl/lfu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### rtl/lfu_scan.sv
// Scan unit: walks the slot memory read stream, finds the first key match
// and the least-used, oldest slot. Depends on lfu_pkg.
`default_nettype none

module lfu_scan #(
	parameter int ENTRIES = 16,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clear,
	input  wire logic                       rd_valid,
	input  wire logic [IDX_W-1:0]           rd_index,
	input  wire lfu_pkg::lfu_entry_t        rd_entry,
	input  wire logic [lfu_pkg::DATA_W-1:0] key,
	output lfu_pkg::lfu_scan_t              result,
	output logic      [IDX_W-1:0]           match_index,
	output logic      [IDX_W-1:0]           victim_index
);

	import lfu_pkg::*;

	logic       match_found_q;
	logic       have_victim_q;
	lfu_entry_t match_entry_q;
	lfu_entry_t victim_entry_q;
	logic [IDX_W-1:0] match_index_q;
	logic [IDX_W-1:0] victim_index_q;
	logic       key_eq;
	logic       lower;

	assign key_eq = (rd_entry.key == key);
	// lower count wins; equal counts go to the older stamp; full tie keeps earlier slot
	assign lower  = {rd_entry.use_count, rd_entry.order_stamp}
		< {victim_entry_q.use_count, victim_entry_q.order_stamp};

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			have_victim_q <= 1'b0;
		end else if (clear) begin
			match_found_q <= 1'b0;
			have_victim_q <= 1'b0;
		end else if (rd_valid) begin
			if (key_eq) begin
				match_found_q <= 1'b1;
			end
			have_victim_q <= 1'b1;
		end
	end

	// captured slots
	always_ff @(posedge clk) begin
		if (!clear && rd_valid) begin
			if (!match_found_q && key_eq) begin
				match_entry_q <= rd_entry;
				match_index_q <= rd_index;
			end
			if (!have_victim_q || lower) begin
				victim_entry_q <= rd_entry;
				victim_index_q <= rd_index;
			end
		end
	end

	assign result.match_found  = match_found_q;
	assign result.match_entry  = match_entry_q;
	assign result.victim_entry = victim_entry_q;
	assign match_index  = match_index_q;
	assign victim_index = victim_index_q;

endmodule

`default_nettype wire

### rtl/lfu_cache_policy.sv
// Key-value cache with least-frequently-used replacement (oldest-first on ties).
// Each item is a get or a put and gives one result item. Slots are held in one
// synchronous memory and are filled from slot 0 upwards, so the occupied slots
// are always the first fill-count entries. An item is accepted, then each
// occupied slot is read from the memory in turn, then the item's write-back
// and result take place. The single read port of the slot memory makes the
// scan read the slots one after another. A new item is taken while a finished
// result still waits on the output. No clearing pass is needed after reset.
// A capacity above ENTRIES counts as ENTRIES.
// Depends on lfu_pkg, lfu_ram and lfu_scan.
`default_nettype none

module lfu_cache_policy #(
	parameter int ENTRIES = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_wr_en,
	input  wire logic [lfu_pkg::CAP_W-1:0]         cfg_wr_data,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              action,
	input  wire logic signed [lfu_pkg::DATA_W-1:0] lookup_key,
	input  wire logic signed [lfu_pkg::DATA_W-1:0] write_value,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   hit,
	output logic signed [lfu_pkg::DATA_W-1:0]      read_value,
	output logic                                   evicted,
	output logic signed [lfu_pkg::DATA_W-1:0]      evicted_key,
	output logic                                   dropped
);

	import lfu_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int ENT_W = $bits(lfu_entry_t);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);
	localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic              action_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] value_q;
	logic [CAP_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  idx_q;
	logic [DATA_W-1:0] order_q;
	logic              rd_pending_s1;
	logic [IDX_W-1:0]  rd_index_s1;

	logic              out_valid_q;
	logic              hit_q;
	logic [DATA_W-1:0] read_value_q;
	logic              evicted_q;
	logic [DATA_W-1:0] evicted_key_q;
	logic              dropped_q;

	logic              accept;
	logic              out_free;
	logic              finish;
	logic              scan_clear;
	logic              rd_issue;
	lfu_entry_t        rd_entry;
	lfu_scan_t         scan;
	logic [IDX_W-1:0]  match_index;
	logic [IDX_W-1:0]  victim_index;

	// decision
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	lfu_entry_t        wr_entry;
	logic              take_stamp;
	logic              fill_inc;
	logic              res_hit;
	logic [DATA_W-1:0] res_read;
	logic              res_evict;
	logic [DATA_W-1:0] res_evict_key;
	logic              res_drop;
	logic              full;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign finish     = (state_q == ST_DONE) && out_free;
	assign scan_clear = accept;
	assign rd_issue   = (state_q == ST_SCAN) && (idx_q < fill_q);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	// slot memory
	lfu_ram #(
		.WIDTH(ENT_W),
		.DEPTH(ENTRIES)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_entry)
	);

	// match and victim search
	lfu_scan #(
		.ENTRIES(ENTRIES)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (scan_clear),
		.rd_valid     (rd_pending_s1),
		.rd_index     (rd_index_s1),
		.rd_entry     (rd_entry),
		.key          (key_q),
		.result       (scan),
		.match_index  (match_index),
		.victim_index (victim_index)
	);

	// the cache is full at the effective capacity, min(capacity, ENTRIES)
	assign full = (CMP_W'(fill_q) >= CMP_W'(capacity_q)) || (fill_q == FULL_COUNT);

	// outcome and write-back of the item
	always_comb begin
		wr_en         = 1'b0;
		wr_addr       = match_index;
		wr_entry      = scan.match_entry;
		take_stamp    = 1'b0;
		fill_inc      = 1'b0;
		res_hit       = scan.match_found;
		res_read      = '0;
		res_evict     = 1'b0;
		res_evict_key = '0;
		res_drop      = 1'b0;
		wr_entry.use_count   = sat_inc(scan.match_entry.use_count);
		wr_entry.order_stamp = order_q;
		if (scan.match_found) begin
			wr_en      = 1'b1;
			take_stamp = 1'b1;
			if (action_q == ACT_GET) begin
				res_read = scan.match_entry.value;
			end else begin
				wr_entry.value = value_q;
			end
		end else if (action_q == ACT_GET) begin
			res_read = GET_MISS_VALUE;
		end else if (capacity_q == '0) begin
			res_drop = 1'b1;
		end else begin
			wr_en                = 1'b1;
			take_stamp           = 1'b1;
			wr_entry.key         = key_q;
			wr_entry.value       = value_q;
			wr_entry.use_count   = FIRST_COUNT;
			wr_entry.order_stamp = order_q;
			if (full && (fill_q != '0)) begin
				res_evict     = 1'b1;
				res_evict_key = scan.victim_entry.key;
				wr_addr       = victim_index;
			end else begin
				wr_addr  = fill_q[IDX_W-1:0];
				fill_inc = 1'b1;
			end
		end
		wr_en = wr_en && finish;
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			fill_q        <= '0;
			order_q       <= '0;
			rd_pending_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rd_pending_s1 <= 1'b0;
					if (accept) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_pending_s1 <= rd_issue;
					if (rd_issue) begin
						idx_q <= idx_q + CNT_ONE;
					end else if (!rd_pending_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					rd_pending_s1 <= 1'b0;
					if (finish) begin
						state_q <= ST_IDLE;
						if (take_stamp) begin
							order_q <= sat_inc(order_q);
						end
						if (fill_inc) begin
							fill_q <= fill_q + CNT_ONE;
						end
					end
				end
				default: begin
					state_q       <= ST_IDLE;
					rd_pending_s1 <= 1'b0;
				end
			endcase
		end
	end

	// item capture and read index pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			key_q    <= lookup_key;
			value_q  <= write_value;
		end
		rd_index_s1 <= idx_q[IDX_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q         <= res_hit;
			read_value_q  <= res_read;
			evicted_q     <= res_evict;
			evicted_key_q <= res_evict_key;
			dropped_q     <= res_drop;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;
	assign dropped     = dropped_q;

endmodule

`default_nettype wire
